// ===== rtl/core/rvdec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV64I decode package
// Types, codes and constants shared by the decode stage and its decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam int unsigned RegCount   = 32;
  localparam int unsigned RegIdxW    = 5;
  localparam int unsigned XLen       = 64;
  localparam int unsigned MemBytesDefault = 262144;
  localparam logic [RegIdxW-1:0] RegSp = 5'd2;

  typedef enum logic {
    REQ_DECODE = 1'b0,
    REQ_WRITE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOT32  = 2'd1,
    ST_UNIMPL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CAT_LOAD      = 4'd0,
    CAT_STORE     = 4'd1,
    CAT_BRANCH    = 4'd2,
    CAT_JALR      = 4'd3,
    CAT_JAL       = 4'd4,
    CAT_OP_IMM    = 4'd5,
    CAT_OP        = 4'd6,
    CAT_AUIPC     = 4'd7,
    CAT_LUI       = 4'd8,
    CAT_OP_IMM_32 = 4'd9,
    CAT_OP_32     = 4'd10,
    CAT_SYSTEM    = 4'd11,
    CAT_UNIMPL    = 4'd12
  } cat_e;

  localparam logic [4:0] OPC_LOAD      = 5'h00;
  localparam logic [4:0] OPC_OP_IMM    = 5'h04;
  localparam logic [4:0] OPC_AUIPC     = 5'h05;
  localparam logic [4:0] OPC_OP_IMM_32 = 5'h06;
  localparam logic [4:0] OPC_STORE     = 5'h08;
  localparam logic [4:0] OPC_OP        = 5'h0c;
  localparam logic [4:0] OPC_LUI       = 5'h0d;
  localparam logic [4:0] OPC_OP_32     = 5'h0e;
  localparam logic [4:0] OPC_BRANCH    = 5'h18;
  localparam logic [4:0] OPC_JALR      = 5'h19;
  localparam logic [4:0] OPC_JAL       = 5'h1b;
  localparam logic [4:0] OPC_SYSTEM    = 5'h1c;

  typedef struct packed {
    status_e              status;
    cat_e                 category;
    logic [RegIdxW-1:0]   rd;
    logic [2:0]           f3;
    logic [6:0]           f7;
    logic [31:0]          imm;
    logic                 use_rs1;
    logic                 use_rs2;
    logic                 use_iimm;
    logic [11:0]          iimm;
    logic [RegIdxW-1:0]   rs1;
    logic [RegIdxW-1:0]   rs2;
  } dec_t;

  function automatic cat_e opc_category(input logic [4:0] opc);
    cat_e cat;
    case (opc)
      OPC_LOAD:      cat = CAT_LOAD;
      OPC_OP_IMM:    cat = CAT_OP_IMM;
      OPC_AUIPC:     cat = CAT_AUIPC;
      OPC_OP_IMM_32: cat = CAT_OP_IMM_32;
      OPC_STORE:     cat = CAT_STORE;
      OPC_OP:        cat = CAT_OP;
      OPC_LUI:       cat = CAT_LUI;
      OPC_OP_32:     cat = CAT_OP_32;
      OPC_BRANCH:    cat = CAT_BRANCH;
      OPC_JALR:      cat = CAT_JALR;
      OPC_JAL:       cat = CAT_JAL;
      OPC_SYSTEM:    cat = CAT_SYSTEM;
      default:       cat = CAT_UNIMPL;
    endcase
    return cat;
  endfunction

endpackage

// ===== rtl/core/rvdec_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rvdec_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rvdec_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV64I instruction field decoder
// Classifies an instruction word and extracts its fields and immediates.
// ----------------------------------------------------------------------------
module rvdec_decode (
  input  logic [31:0]       instr_i,
  output rvdec_pkg::dec_t   dec_o
);

  rvdec_pkg::cat_e cat;
  logic [31:0]     w;

  assign w   = instr_i;
  assign cat = rvdec_pkg::opc_category(w[6:2]);

  always_comb begin
    dec_o          = '0;
    dec_o.status   = rvdec_pkg::ST_OK;
    dec_o.category = rvdec_pkg::CAT_UNIMPL;
    dec_o.rs1      = w[19:15];
    dec_o.rs2      = w[24:20];
    dec_o.iimm     = w[31:20];
    if (w[1:0] != 2'b11) begin
      dec_o.status = rvdec_pkg::ST_NOT32;
    end else begin
      dec_o.category = cat;
      case (cat)
        rvdec_pkg::CAT_LOAD, rvdec_pkg::CAT_JALR, rvdec_pkg::CAT_OP_IMM,
        rvdec_pkg::CAT_OP_IMM_32, rvdec_pkg::CAT_SYSTEM: begin
          dec_o.rd       = w[11:7];
          dec_o.f3       = w[14:12];
          dec_o.use_rs1  = 1'b1;
          dec_o.use_iimm = 1'b1;
        end
        rvdec_pkg::CAT_STORE: begin
          dec_o.f3      = w[14:12];
          dec_o.use_rs1 = 1'b1;
          dec_o.use_rs2 = 1'b1;
          dec_o.imm     = {{20{w[31]}}, w[31:25], w[11:7]};
        end
        rvdec_pkg::CAT_BRANCH: begin
          dec_o.f3      = w[14:12];
          dec_o.use_rs1 = 1'b1;
          dec_o.use_rs2 = 1'b1;
          dec_o.imm     = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        rvdec_pkg::CAT_AUIPC, rvdec_pkg::CAT_LUI: begin
          dec_o.rd  = w[11:7];
          dec_o.imm = {w[31:12], 12'b0};
        end
        rvdec_pkg::CAT_JAL: begin
          dec_o.rd  = w[11:7];
          dec_o.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        rvdec_pkg::CAT_OP, rvdec_pkg::CAT_OP_32: begin
          dec_o.rd      = w[11:7];
          dec_o.f3      = w[14:12];
          dec_o.f7      = w[31:25];
          dec_o.use_rs1 = 1'b1;
          dec_o.use_rs2 = 1'b1;
        end
        default: begin
          dec_o.status   = rvdec_pkg::ST_UNIMPL;
          dec_o.category = rvdec_pkg::CAT_UNIMPL;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rv64i_instruction_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV64I instruction decode unit
// Decode stage with its 32 x 64-bit register file.
// ----------------------------------------------------------------------------
// The unit accepts one request per cycle while in_stall_o is low. A decode
// request yields one result: the register file sits in two copies of a
// synchronous RAM, one per source operand, whose registered read data pass
// through the output register. A write request loads one register and
// yields no result; a decode request accepted in the next cycle already
// sees the new value. Register x0 is an ordinary register. After
// reset every register reads zero except x2, which reads MemoryBytes; a
// per-register valid bit stands in for the reset contents until written.
module rv64i_instruction_decoder_unit #(
  parameter int unsigned MemoryBytes = rvdec_pkg::MemBytesDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [31:0]                        instruction_word_i,
  input  logic [rvdec_pkg::RegIdxW-1:0]      write_index_i,
  input  logic signed [rvdec_pkg::XLen-1:0]  write_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [3:0]                         category_o,
  output logic [rvdec_pkg::RegIdxW-1:0]      dest_reg_o,
  output logic [2:0]                         func3_o,
  output logic [6:0]                         func7_o,
  output logic signed [31:0]                 imm_offset_o,
  output logic signed [rvdec_pkg::XLen-1:0]  left_value_o,
  output logic signed [rvdec_pkg::XLen-1:0]  right_value_o
);

  localparam int unsigned XLen = rvdec_pkg::XLen;

  logic                          accept;
  logic                          dec_req;
  logic                          wr_req;
  rvdec_pkg::dec_t               dec;
  logic [XLen-1:0]               rdata1;
  logic [XLen-1:0]               rdata2;
  logic [XLen-1:0]               op1;
  logic [XLen-1:0]               op2;
  logic [XLen-1:0]               left_d;
  logic [XLen-1:0]               right_d;
  logic                          s1_adv;

  logic [rvdec_pkg::RegCount-1:0] vld_q, vld_d;
  logic                          s1_valid_q, s1_valid_d;
  rvdec_pkg::dec_t               s1_dec_q;
  logic                          s1_vld1_q;
  logic                          s1_vld2_q;
  logic                          s2_valid_q, s2_valid_d;
  rvdec_pkg::dec_t               s2_dec_q;
  logic [XLen-1:0]               s2_left_q;
  logic [XLen-1:0]               s2_right_q;

  function automatic logic [XLen-1:0] reset_value(input logic [rvdec_pkg::RegIdxW-1:0] idx);
    return (idx == rvdec_pkg::RegSp) ? XLen'(MemoryBytes) : '0;
  endfunction

  assign accept     = in_valid_i && !in_stall_o;
  assign dec_req    = accept && (opcode_i == rvdec_pkg::REQ_DECODE);
  assign wr_req     = accept && (opcode_i == rvdec_pkg::REQ_WRITE);
  assign s1_adv     = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && s2_valid_q && out_stall_i;

  rvdec_decode u_decode (
    .instr_i (instruction_word_i),
    .dec_o   (dec)
  );

  rvdec_ram #(
    .Width (XLen),
    .Depth (rvdec_pkg::RegCount)
  ) u_rf_rs1 (
    .clk_i   (clk_i),
    .we_i    (wr_req),
    .waddr_i (write_index_i),
    .wdata_i (write_value_i),
    .re_i    (dec_req),
    .raddr_i (dec.rs1),
    .rdata_o (rdata1)
  );

  rvdec_ram #(
    .Width (XLen),
    .Depth (rvdec_pkg::RegCount)
  ) u_rf_rs2 (
    .clk_i   (clk_i),
    .we_i    (wr_req),
    .waddr_i (write_index_i),
    .wdata_i (write_value_i),
    .re_i    (dec_req),
    .raddr_i (dec.rs2),
    .rdata_o (rdata2)
  );

  always_comb begin
    vld_d = vld_q;
    if (wr_req) begin
      vld_d[write_index_i] = 1'b1;
    end
    s1_valid_d = dec_req || (s1_valid_q && !s1_adv);
    if (s1_adv) begin
      s2_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_d = 1'b0;
    end else begin
      s2_valid_d = s2_valid_q;
    end
  end

  always_comb begin
    op1     = s1_vld1_q ? rdata1 : reset_value(s1_dec_q.rs1);
    op2     = s1_vld2_q ? rdata2 : reset_value(s1_dec_q.rs2);
    left_d  = s1_dec_q.use_rs1 ? op1 : '0;
    right_d = '0;
    if (s1_dec_q.use_rs2) begin
      right_d = op2;
    end else if (s1_dec_q.use_iimm) begin
      right_d = {{(XLen-12){s1_dec_q.iimm[11]}}, s1_dec_q.iimm};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      vld_q      <= vld_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_req) begin
      s1_dec_q  <= dec;
      s1_vld1_q <= vld_q[dec.rs1];
      s1_vld2_q <= vld_q[dec.rs2];
    end
    if (s1_adv) begin
      s2_dec_q   <= s1_dec_q;
      s2_left_q  <= left_d;
      s2_right_q <= right_d;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign status_o      = s2_dec_q.status;
  assign category_o    = s2_dec_q.category;
  assign dest_reg_o    = s2_dec_q.rd;
  assign func3_o       = s2_dec_q.f3;
  assign func7_o       = s2_dec_q.f7;
  assign imm_offset_o  = s2_dec_q.imm;
  assign left_value_o  = s2_left_q;
  assign right_value_o = s2_right_q;

endmodule
